/* rtl/core/int64_divide_with_remainder_unit_defines.svh */
// Assertion macros for the divider core.
`ifndef INT64_DIVIDE_WITH_REMAINDER_UNIT_DEFINES_SVH
`define INT64_DIVIDE_WITH_REMAINDER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IDIV64_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("idiv64 same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define IDIV64_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("idiv64 next-cycle check failed");

`endif

/* rtl/core/idiv64_pkg.sv */
`timescale 1ns / 1ps
package idiv64_pkg;

  localparam int WORD_W = 64;

  typedef struct packed {
    logic              command;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] quotient;
    logic [WORD_W-1:0] remainder;
    logic              divide_by_zero;
  } out_t;

  // sign fix-up and zero-divisor flag carried along the cell row
  typedef struct packed {
    logic neg_q;
    logic neg_r;
    logic dz;
  } ctl_t;

  localparam logic CMD_UNSIGNED = 1'b0;
  localparam logic CMD_SIGNED   = 1'b1;

endpackage

/* rtl/core/idiv64_prep.sv */
`timescale 1ns / 1ps
module idiv64_prep #(
  parameter int W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  idiv64_pkg::in_t   up_item,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic [W-1:0]      n_mag,
  output logic [W-1:0]      d_mag,
  output idiv64_pkg::ctl_t  ctl
);

  logic             valid_r, valid_nxt;
  logic [W-1:0]     n_raw, d_raw, n_abs, d_abs;
  logic             n_neg, d_neg, is_signed;
  logic [W-1:0]     n_r, d_r;
  idiv64_pkg::ctl_t ctl_r, ctl_nxt;

  always_comb begin
    is_signed = (up_item.command == idiv64_pkg::CMD_SIGNED);
    n_raw     = up_item.dividend[W-1:0];
    d_raw     = up_item.divisor[W-1:0];
    n_neg     = is_signed & n_raw[W-1];
    d_neg     = is_signed & d_raw[W-1];
    n_abs     = n_neg ? ('0 - n_raw) : n_raw;
    d_abs     = d_neg ? ('0 - d_raw) : d_raw;
    ctl_nxt.neg_q = n_neg ^ d_neg;
    ctl_nxt.neg_r = n_neg;
    ctl_nxt.dz    = (d_raw == '0);
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      n_r   <= n_abs;
      d_r   <= d_abs;
      ctl_r <= ctl_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign n_mag    = n_r;
  assign d_mag    = d_r;
  assign ctl      = ctl_r;

endmodule

/* rtl/core/idiv64_cell.sv */
`timescale 1ns / 1ps
module idiv64_cell #(
  parameter int W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [W-1:0]      rem_i,
  input  logic [W-1:0]      nq_i,
  input  logic [W-1:0]      div_i,
  input  idiv64_pkg::ctl_t  ctl_i,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic [W-1:0]      rem_o,
  output logic [W-1:0]      nq_o,
  output logic [W-1:0]      div_o,
  output idiv64_pkg::ctl_t  ctl_o
);

  // nq holds the unused dividend bits on top and the quotient bits below
  logic             valid_r, valid_nxt;
  logic [W:0]       shifted;
  logic [W+1:0]     trial;
  logic             borrow;
  logic [W-1:0]     rem_nxt, nq_nxt;
  logic [W-1:0]     rem_r, nq_r, div_r;
  idiv64_pkg::ctl_t ctl_r;

  always_comb begin
    shifted = {rem_i, nq_i[W-1]};
    trial   = {1'b0, shifted} - {2'b00, div_i};
    borrow  = trial[W+1];
    rem_nxt = borrow ? shifted[W-1:0] : trial[W-1:0];
    nq_nxt  = {nq_i[W-2:0], ~borrow};
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
      div_r <= div_i;
      ctl_r <= ctl_i;
    end
  end

  assign dn_valid = valid_r;
  assign rem_o    = rem_r;
  assign nq_o     = nq_r;
  assign div_o    = div_r;
  assign ctl_o    = ctl_r;

endmodule

/* rtl/core/idiv64_post.sv */
`timescale 1ns / 1ps
module idiv64_post #(
  parameter int W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [W-1:0]      quo_i,
  input  logic [W-1:0]      rem_i,
  input  idiv64_pkg::ctl_t  ctl_i,
  output logic              dn_valid,
  input  logic              dn_ready,
  output idiv64_pkg::out_t  dn_item
);

  logic             valid_r, valid_nxt;
  logic [W-1:0]     q_fix, r_fix;
  idiv64_pkg::out_t item_nxt, item_r;

  always_comb begin
    q_fix    = ctl_i.neg_q ? ('0 - quo_i) : quo_i;
    r_fix    = ctl_i.neg_r ? ('0 - rem_i) : rem_i;
    item_nxt = '0;
    item_nxt.quotient[W-1:0]  = q_fix;
    item_nxt.remainder[W-1:0] = r_fix;
    item_nxt.divide_by_zero   = ctl_i.dz;
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

/* rtl/core/int64_divide_with_remainder_unit.sv */
`timescale 1ns / 1ps
// Pipelined signed/unsigned divider with remainder. Accepts one item per
// clock while the output is not stalled: a prep stage takes operand
// magnitudes, a row of DATA_WIDTH subtract cells produces one quotient bit
// each, and a last stage applies signs. Each stage moves independently, so
// bubbles are squeezed out while the output is stalled. A zero divisor sets
// divide_by_zero and gives an all-ones quotient (1 for a negative signed
// dividend) and the dividend as remainder; the most negative value divided
// by minus one wraps to itself with remainder 0. Operand bits above
// DATA_WIDTH are ignored and result bits above DATA_WIDTH are zero.
`include "int64_divide_with_remainder_unit_defines.svh"
module int64_divide_with_remainder_unit #(
  parameter int DATA_WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  idiv64_pkg::in_t  in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output idiv64_pkg::out_t out_item
);

  localparam int W = DATA_WIDTH;

  logic [W-1:0]     rem_c [0:W];
  logic [W-1:0]     nq_c  [0:W];
  logic [W-1:0]     div_c [0:W];
  idiv64_pkg::ctl_t ctl_c [0:W];
  logic             vld_c [0:W];
  logic             rdy_c [0:W];
  logic             prep_ready;

  assign rem_c[0] = '0;
  assign in_stall = !prep_ready;

  idiv64_prep #(.W(W)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (prep_ready),
    .up_item  (in_item),
    .dn_valid (vld_c[0]),
    .dn_ready (rdy_c[0]),
    .n_mag    (nq_c[0]),
    .d_mag    (div_c[0]),
    .ctl      (ctl_c[0])
  );

  for (genvar k = 1; k <= W; k++) begin : g_cell
    idiv64_cell #(.W(W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld_c[k-1]),
      .up_ready (rdy_c[k-1]),
      .rem_i    (rem_c[k-1]),
      .nq_i     (nq_c[k-1]),
      .div_i    (div_c[k-1]),
      .ctl_i    (ctl_c[k-1]),
      .dn_valid (vld_c[k]),
      .dn_ready (rdy_c[k]),
      .rem_o    (rem_c[k]),
      .nq_o     (nq_c[k]),
      .div_o    (div_c[k]),
      .ctl_o    (ctl_c[k])
    );
  end

  idiv64_post #(.W(W)) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (vld_c[W]),
    .up_ready (rdy_c[W]),
    .quo_i    (nq_c[W]),
    .rem_i    (rem_c[W]),
    .ctl_i    (ctl_c[W]),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_item  (out_item)
  );

  `IDIV64_ASSERT_IMPLY(a_dz_quotient, clk, rst_n, out_valid && out_item.divide_by_zero, (out_item.quotient[W-1:0] == {W{1'b1}}) || (out_item.quotient == idiv64_pkg::WORD_W'(1)))
  `IDIV64_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_valid && !in_stall, vld_c[0])
  `IDIV64_ASSERT_IMPLY(a_ready_chain, clk, rst_n, !out_stall, !in_stall)

endmodule
